@@ rtl/core/iterative_lens_undistort_unit_macros.svh @@
// assertion macros for the lens undistortion top level
`ifndef ITERATIVE_LENS_UNDISTORT_UNIT_MACROS_SVH
`define ITERATIVE_LENS_UNDISTORT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off while rst_n is low
`define ILU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, clocked on clk, off while rst_n is low
`define ILU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ILU_ASSERT_IMP(lbl, ante, cons, msg)
`define ILU_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/ilu_pkg.sv @@
// types, constants and fixed-point helpers for the lens undistortion unit
package ilu_pkg;

  localparam int ITERATIONS = 5;
  localparam int FRAC       = 24;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_QBITS  = 32;
  localparam int DIV_STAGES = DIV_QBITS / DIV_STEPS;
  localparam int DIV_NUM_W  = 50;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X   = 4'd0,
    REG_FOCAL_Y   = 4'd1,
    REG_PRINCIPAL = 4'd2,
    REG_RADIAL_K1 = 4'd3,
    REG_RADIAL_K2 = 4'd4,
    REG_RADIAL_K3 = 4'd5,
    REG_TAN_P1    = 4'd6,
    REG_TAN_P2    = 4'd7
  } cfg_reg_t;

  typedef logic signed [31:0] q24_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [23:0] pix_t;

  localparam q24_t Q_MAX = 32'sh7fff_ffff;
  localparam q24_t Q_MIN = 32'sh8000_0000;
  localparam q24_t ONE_Q = 32'sh0100_0000;

  typedef struct packed {
    logic [23:0] focal_x;
    logic [23:0] focal_y;
    logic [23:0] cx;
    logic [23:0] cy;
    q24_t        k1;
    q24_t        k2;
    q24_t        k3;
    q24_t        p1;
    q24_t        p2;
  } cfg_t;

  // one point in flight through the iterations
  typedef struct packed {
    logic vld;
    logic flag;
    q24_t x0;
    q24_t y0;
    q24_t x;
    q24_t y;
  } pt_t;

  // clamp a 41-bit signed value to q8.24 full scale
  function automatic q24_t sat32(input logic signed [40:0] v);
    if (v[40:31] == {10{v[40]}}) begin
      return v[31:0];
    end
    return v[40] ? Q_MIN : Q_MAX;
  endfunction

  // product back to q8.24, nearest with ties upward
  function automatic logic signed [39:0] qround(input prod_t p);
    prod_t t;
    t = p + 64'sd8388608;
    return t[63:FRAC];
  endfunction

  function automatic q24_t qmul_sat(input prod_t p);
    logic signed [39:0] r;
    r = qround(p);
    return sat32({r[39], r});
  endfunction

  function automatic q24_t add_sat(input q24_t a, input q24_t b);
    return sat32({{9{a[31]}}, a} + {{9{b[31]}}, b});
  endfunction

  function automatic q24_t sub_sat(input q24_t a, input q24_t b);
    return sat32({{9{a[31]}}, a} - {{9{b[31]}}, b});
  endfunction

  // product clamped to q8.24 first, then the constant added and clamped again
  function automatic q24_t round_add_sat(input prod_t p, input q24_t c);
    return add_sat(qmul_sat(p), c);
  endfunction

  // unsigned quotient with overflow flag to signed q8.24, negated when neg
  function automatic q24_t quo_to_q24(input logic [31:0] q, input logic ovf,
                                      input logic neg);
    if (!neg) begin
      return (ovf || q[31]) ? Q_MAX : q24_t'(q);
    end
    if (ovf || (q[31] && (q[30:0] != 31'd0))) begin
      return Q_MIN;
    end
    return q24_t'(32'd0 - q);
  endfunction

endpackage

@@ rtl/core/ilu_div.sv @@
// pipelined restoring divider, fixed number of quotient bits per stage
module ilu_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ilu_pkg::DIV_NUM_W-1:0] num,
  input  logic [ilu_pkg::DIV_QBITS-1:0] den,
  output logic [ilu_pkg::DIV_QBITS-1:0] quo,
  output logic                          ovf
);
  import ilu_pkg::*;

  typedef struct packed {
    logic [DIV_QBITS-1:0] rem;
    logic [DIV_QBITS-1:0] sh;
    logic [DIV_QBITS-1:0] den;
    logic                 ovf;
  } dstage_t;

  dstage_t st_in;
  dstage_t st_nxt [DIV_STAGES];
  dstage_t st_r   [DIV_STAGES];

  function automatic dstage_t div_steps(input dstage_t s);
    dstage_t            r;
    logic [DIV_QBITS:0] t;
    r = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {r.rem, r.sh[DIV_QBITS-1]};
      r.sh = {r.sh[DIV_QBITS-2:0], 1'b0};
      if (t >= {1'b0, r.den}) begin
        t = t - {1'b0, r.den};
        r.sh[0] = 1'b1;
      end
      r.rem = t[DIV_QBITS-1:0];
    end
    return r;
  endfunction

  // upper numerator bits start the remainder; at or above the divisor means overflow
  always_comb begin
    st_in.rem = DIV_QBITS'(num[DIV_NUM_W-1:DIV_QBITS]);
    st_in.sh  = num[DIV_QBITS-1:0];
    st_in.den = den;
    st_in.ovf = (DIV_QBITS'(num[DIV_NUM_W-1:DIV_QBITS]) >= den);
  end

  always_comb begin
    st_nxt[0] = div_steps(st_in);
    for (int s = 1; s < DIV_STAGES; s++) begin
      st_nxt[s] = div_steps(st_r[s-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  assign quo = st_r[DIV_STAGES-1].sh;
  assign ovf = st_r[DIV_STAGES-1].ovf;

endmodule

@@ rtl/core/ilu_iter.sv @@
// one pipelined step of the distortion inversion
module ilu_iter (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  ilu_pkg::cfg_t cfg,
  input  ilu_pkg::pt_t  pt_in,
  output ilu_pkg::pt_t  pt_out
);
  import ilu_pkg::*;

  pt_t   a_pt_r, b_pt_r, c_pt_r, d_pt_r, e_pt_r, f_pt_r, g_pt_r, h_pt_r, i_pt_r;
  pt_t   k_pt_r, l_pt_r;
  prod_t a_xx_r, a_yy_r, a_xy_r;
  q24_t  b_xx_r, b_yy_r, b_xy_r;
  q24_t  c_r2_r, c_xx2_r, c_yy2_r, c_xy2_r;
  prod_t d_pk_r;
  q24_t  d_r2_r, d_xy2_r, d_sa_r, d_sb_r;
  q24_t  e_t_r, e_r2_r;
  prod_t e_pp1_r, e_pp2_r, e_pp3_r, e_pp4_r;
  prod_t f_pk_r;
  q24_t  f_r2_r, f_q1_r, f_q2_r, f_q3_r, f_q4_r;
  q24_t  g_t_r, g_r2_r, g_dx_r, g_dy_r;
  prod_t h_pk_r;
  q24_t  h_sx_r, h_sy_r;
  q24_t  i_d_r, i_sx_r, i_sy_r;
  pt_t   dl_pt_r  [DIV_STAGES];
  q24_t  dl_sx_r  [DIV_STAGES];
  q24_t  dl_sy_r  [DIV_STAGES];
  logic  dl_pos_r [DIV_STAGES];
  logic  k_pos_r;
  prod_t k_px_r, k_py_r;

  logic                 i_pos;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_QBITS-1:0] div_den;
  logic [DIV_QBITS-1:0] div_quo;
  logic                 div_ovf;
  q24_t                 ic;

  // 2^48 + d/2 never carries, so the numerator is a plain bit merge
  assign i_pos   = !i_d_r[31] && (i_d_r != 32'sd0);
  assign div_num = (DIV_NUM_W'(1) << (2 * FRAC)) | DIV_NUM_W'(i_d_r[30:1]);
  assign div_den = i_pos ? DIV_QBITS'(i_d_r) : DIV_QBITS'(1);
  assign ic      = quo_to_q24(div_quo, div_ovf, 1'b0);

  ilu_div u_div (
    .clk (clk),
    .en  (en),
    .num (div_num),
    .den (div_den),
    .quo (div_quo),
    .ovf (div_ovf)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_pt_r.vld <= 1'b0;
      b_pt_r.vld <= 1'b0;
      c_pt_r.vld <= 1'b0;
      d_pt_r.vld <= 1'b0;
      e_pt_r.vld <= 1'b0;
      f_pt_r.vld <= 1'b0;
      g_pt_r.vld <= 1'b0;
      h_pt_r.vld <= 1'b0;
      i_pt_r.vld <= 1'b0;
      k_pt_r.vld <= 1'b0;
      l_pt_r.vld <= 1'b0;
      for (int i = 0; i < DIV_STAGES; i++) begin
        dl_pt_r[i].vld <= 1'b0;
      end
    end else if (en) begin
      // squares and cross product
      a_pt_r  <= pt_in;
      a_xx_r  <= pt_in.x * pt_in.x;
      a_yy_r  <= pt_in.y * pt_in.y;
      a_xy_r  <= pt_in.x * pt_in.y;
      b_pt_r  <= a_pt_r;
      b_xx_r  <= qmul_sat(a_xx_r);
      b_yy_r  <= qmul_sat(a_yy_r);
      b_xy_r  <= qmul_sat(a_xy_r);
      c_pt_r  <= b_pt_r;
      c_r2_r  <= add_sat(b_xx_r, b_yy_r);
      c_xx2_r <= add_sat(b_xx_r, b_xx_r);
      c_yy2_r <= add_sat(b_yy_r, b_yy_r);
      c_xy2_r <= add_sat(b_xy_r, b_xy_r);
      // radial polynomial by horner, tangential terms alongside
      d_pt_r  <= c_pt_r;
      d_pk_r  <= cfg.k3 * c_r2_r;
      d_r2_r  <= c_r2_r;
      d_xy2_r <= c_xy2_r;
      d_sa_r  <= add_sat(c_r2_r, c_xx2_r);
      d_sb_r  <= add_sat(c_r2_r, c_yy2_r);
      e_pt_r  <= d_pt_r;
      e_t_r   <= round_add_sat(d_pk_r, cfg.k2);
      e_r2_r  <= d_r2_r;
      e_pp1_r <= cfg.p1 * d_xy2_r;
      e_pp2_r <= cfg.p2 * d_sa_r;
      e_pp3_r <= cfg.p1 * d_sb_r;
      e_pp4_r <= cfg.p2 * d_xy2_r;
      f_pt_r  <= e_pt_r;
      f_pk_r  <= e_t_r * e_r2_r;
      f_r2_r  <= e_r2_r;
      f_q1_r  <= qmul_sat(e_pp1_r);
      f_q2_r  <= qmul_sat(e_pp2_r);
      f_q3_r  <= qmul_sat(e_pp3_r);
      f_q4_r  <= qmul_sat(e_pp4_r);
      g_pt_r  <= f_pt_r;
      g_t_r   <= round_add_sat(f_pk_r, cfg.k1);
      g_r2_r  <= f_r2_r;
      g_dx_r  <= add_sat(f_q1_r, f_q2_r);
      g_dy_r  <= add_sat(f_q3_r, f_q4_r);
      h_pt_r  <= g_pt_r;
      h_pk_r  <= g_t_r * g_r2_r;
      h_sx_r  <= sub_sat(g_pt_r.x0, g_dx_r);
      h_sy_r  <= sub_sat(g_pt_r.y0, g_dy_r);
      i_pt_r  <= h_pt_r;
      i_d_r   <= round_add_sat(h_pk_r, ONE_Q);
      i_sx_r  <= h_sx_r;
      i_sy_r  <= h_sy_r;
      // side data waits alongside the reciprocal divider
      dl_pt_r[0]  <= i_pt_r;
      dl_sx_r[0]  <= i_sx_r;
      dl_sy_r[0]  <= i_sy_r;
      dl_pos_r[0] <= i_pos;
      for (int i = 1; i < DIV_STAGES; i++) begin
        dl_pt_r[i]  <= dl_pt_r[i-1];
        dl_sx_r[i]  <= dl_sx_r[i-1];
        dl_sy_r[i]  <= dl_sy_r[i-1];
        dl_pos_r[i] <= dl_pos_r[i-1];
      end
      k_pt_r  <= dl_pt_r[DIV_STAGES-1];
      k_pos_r <= dl_pos_r[DIV_STAGES-1];
      k_px_r  <= dl_sx_r[DIV_STAGES-1] * ic;
      k_py_r  <= dl_sy_r[DIV_STAGES-1] * ic;
      // non-positive denominator keeps the previous estimate
      l_pt_r <= k_pt_r;
      if (k_pos_r) begin
        l_pt_r.x <= qmul_sat(k_px_r);
        l_pt_r.y <= qmul_sat(k_py_r);
      end else begin
        l_pt_r.flag <= 1'b1;
      end
    end
  end

  assign pt_out = l_pt_r;

endmodule

@@ rtl/core/iterative_lens_undistort_unit.sv @@
// top level of the iterative lens undistortion unit
//
// in_*  : one distorted pixel per transaction, tdata = {distorted_y, distorted_x}
// out_* : one corrected pixel per transaction, tdata = {undistorted_y, undistorted_x},
//         tuser = degenerate (denominator not positive or output clamped)
// cfg_* : register writes, index 0..7 as focal_x, focal_y, principal_point,
//         k1, k2, k3, p1, p2; other indexes are dropped; always ready
//
// one pixel enters every cycle while the pipeline is not halted. on its way the result
// passes three normalising stages, a 16-stage divider for the focal division, a start
// point register, then five inversion steps of 27 stages each
// (nine for the polynomial, 16 for the reciprocal divider, two for the scale),
// then two stages back to pixels
//
// the whole pipeline moves on one enable: it halts while a finished result sits
// unclaimed in the output register, so nothing is dropped or repeated, and
// in_tready falls with it
// reset clears all valid bits and loads the default lens: focal 500.0,
// centre (320.0, 240.0), no distortion
module iterative_lens_undistort_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [47:0]                    in_tdata,   // distorted_x, distorted_y
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [47:0]                    out_tdata,  // undistorted_x, undistorted_y
  output logic [0:0]                     out_tuser,  // degenerate
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ilu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ilu_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ilu_pkg::*;

`include "iterative_lens_undistort_unit_macros.svh"

  cfg_t        cfg_r;
  logic        en;
  logic [23:0] fx_e, fy_e;

  // normalising front end
  logic                   n0_vld_r, n1_vld_r, n2_vld_r;
  pix_t                   n0_u_r, n0_v_r;
  logic signed [25:0]     n1_dx_r, n1_dy_r;
  logic [DIV_NUM_W-1:0]   n2_numx_r, n2_numy_r;
  logic                   n2_negx_r, n2_negy_r;
  logic                   dl_vld_r  [DIV_STAGES];
  logic                   dl_negx_r [DIV_STAGES];
  logic                   dl_negy_r [DIV_STAGES];
  logic [DIV_QBITS-1:0]   quox, quoy;
  logic                   ovfx, ovfy;
  pt_t                    n3_pt_r;
  pt_t                    pt_chain [ITERATIONS+1];

  // back to pixels
  logic                   o1_vld_r, o1_flag_r;
  logic signed [56:0]     o1_px_r, o1_py_r;
  logic                   out_valid_r, out_deg_r;
  pix_t                   out_x_r, out_y_r;
  pix_t                   pix_x, pix_y;
  logic                   clip_x, clip_y;

  logic [24:0]            magx, magy;

  // a zero focal register behaves as one lsb
  assign fx_e = (cfg_r.focal_x == 24'd0) ? 24'd1 : cfg_r.focal_x;
  assign fy_e = (cfg_r.focal_y == 24'd0) ? 24'd1 : cfg_r.focal_y;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.focal_x <= 24'd128000;
      cfg_r.focal_y <= 24'd128000;
      cfg_r.cx      <= 24'd81920;
      cfg_r.cy      <= 24'd61440;
      cfg_r.k1      <= '0;
      cfg_r.k2      <= '0;
      cfg_r.k3      <= '0;
      cfg_r.p1      <= '0;
      cfg_r.p2      <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_FOCAL_X: begin
          cfg_r.focal_x <= cfg_data[23:0];
        end
        REG_FOCAL_Y: begin
          cfg_r.focal_y <= cfg_data[23:0];
        end
        REG_PRINCIPAL: begin
          cfg_r.cx <= cfg_data[47:24];
          cfg_r.cy <= cfg_data[23:0];
        end
        REG_RADIAL_K1: begin
          cfg_r.k1 <= cfg_data[31:0];
        end
        REG_RADIAL_K2: begin
          cfg_r.k2 <= cfg_data[31:0];
        end
        REG_RADIAL_K3: begin
          cfg_r.k3 <= cfg_data[31:0];
        end
        REG_TAN_P1: begin
          cfg_r.p1 <= cfg_data[31:0];
        end
        REG_TAN_P2: begin
          cfg_r.p2 <= cfg_data[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  // magnitudes of the centred offsets for the unsigned divider
  assign magx = n1_dx_r[25] ? 25'(-n1_dx_r) : n1_dx_r[24:0];
  assign magy = n1_dy_r[25] ? 25'(-n1_dy_r) : n1_dy_r[24:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n0_vld_r <= 1'b0;
      n1_vld_r <= 1'b0;
      n2_vld_r <= 1'b0;
      n3_pt_r.vld <= 1'b0;
      for (int i = 0; i < DIV_STAGES; i++) begin
        dl_vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      n0_vld_r <= in_tvalid;
      n0_u_r   <= in_tdata[23:0];
      n0_v_r   <= in_tdata[47:24];
      // centre the pixel
      n1_vld_r <= n0_vld_r;
      n1_dx_r  <= {{2{n0_u_r[23]}}, n0_u_r} - $signed({2'b00, cfg_r.cx});
      n1_dy_r  <= {{2{n0_v_r[23]}}, n0_v_r} - $signed({2'b00, cfg_r.cy});
      // |offset| * 2^24 plus half the focal length, rounded division follows
      n2_vld_r  <= n1_vld_r;
      n2_negx_r <= n1_dx_r[25];
      n2_negy_r <= n1_dy_r[25];
      n2_numx_r <= DIV_NUM_W'({magx, 24'd0}) + DIV_NUM_W'(fx_e[23:1]);
      n2_numy_r <= DIV_NUM_W'({magy, 24'd0}) + DIV_NUM_W'(fy_e[23:1]);
      dl_vld_r[0]  <= n2_vld_r;
      dl_negx_r[0] <= n2_negx_r;
      dl_negy_r[0] <= n2_negy_r;
      for (int i = 1; i < DIV_STAGES; i++) begin
        dl_vld_r[i]  <= dl_vld_r[i-1];
        dl_negx_r[i] <= dl_negx_r[i-1];
        dl_negy_r[i] <= dl_negy_r[i-1];
      end
      // normalised start point, the first estimate is the point itself
      n3_pt_r.vld  <= dl_vld_r[DIV_STAGES-1];
      n3_pt_r.flag <= 1'b0;
      n3_pt_r.x0   <= quo_to_q24(quox, ovfx, dl_negx_r[DIV_STAGES-1]);
      n3_pt_r.y0   <= quo_to_q24(quoy, ovfy, dl_negy_r[DIV_STAGES-1]);
      n3_pt_r.x    <= quo_to_q24(quox, ovfx, dl_negx_r[DIV_STAGES-1]);
      n3_pt_r.y    <= quo_to_q24(quoy, ovfy, dl_negy_r[DIV_STAGES-1]);
    end
  end

  ilu_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (n2_numx_r),
    .den (DIV_QBITS'(fx_e)),
    .quo (quox),
    .ovf (ovfx)
  );

  ilu_div u_div_y (
    .clk (clk),
    .en  (en),
    .num (n2_numy_r),
    .den (DIV_QBITS'(fy_e)),
    .quo (quoy),
    .ovf (ovfy)
  );

  // chain of inversion steps
  assign pt_chain[0] = n3_pt_r;

  for (genvar g = 0; g < ITERATIONS; g++) begin : g_iter
    ilu_iter u_iter (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .cfg    (cfg_r),
      .pt_in  (pt_chain[g]),
      .pt_out (pt_chain[g+1])
    );
  end

  // rounded scale by focal length, add the centre and clamp to pixel range
  always_comb begin
    logic signed [56:0] tx, ty;
    logic signed [33:0] sx, sy;
    tx = o1_px_r + 57'sd8388608;
    ty = o1_py_r + 57'sd8388608;
    sx = 34'($signed(tx[56:FRAC])) + $signed({10'd0, cfg_r.cx});
    sy = 34'($signed(ty[56:FRAC])) + $signed({10'd0, cfg_r.cy});
    clip_x = (sx[33:23] != {11{sx[33]}});
    clip_y = (sy[33:23] != {11{sy[33]}});
    pix_x  = clip_x ? (sx[33] ? 24'sh800000 : 24'sh7fffff) : sx[23:0];
    pix_y  = clip_y ? (sy[33] ? 24'sh800000 : 24'sh7fffff) : sy[23:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      o1_vld_r    <= pt_chain[ITERATIONS].vld;
      o1_flag_r   <= pt_chain[ITERATIONS].flag;
      o1_px_r     <= pt_chain[ITERATIONS].x * $signed({1'b0, fx_e});
      o1_py_r     <= pt_chain[ITERATIONS].y * $signed({1'b0, fy_e});
      out_valid_r <= o1_vld_r;
      out_x_r     <= pix_x;
      out_y_r     <= pix_y;
      out_deg_r   <= o1_flag_r || clip_x || clip_y;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tuser  = out_deg_r;

  // a stall freezes the inversion chain
  `ILU_ASSERT_NXT(a_stall_freezes, !en, $stable(pt_chain[ITERATIONS].vld), "chain moved in stall")
  // the output register follows the last scale stage
  `ILU_ASSERT_NXT(a_out_fill, en && o1_vld_r, out_valid_r, "result lost at output")
  `ILU_ASSERT_NXT(a_out_drain, en && !o1_vld_r, !out_valid_r, "result repeated at output")

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for the iterative lens undistortion unit
`timescale 1ns / 100ps

module tb_top;
  import ilu_pkg::*;

  localparam int  CLK_HALF    = 2;
  localparam int  DRAIN_WAIT  = 200;      // pipeline is 157 stages deep
  localparam int  CYCLE_LIMIT = 3000000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd11;  // no register behind it

  typedef struct packed {
    logic signed [23:0] y;
    logic signed [23:0] x;
  } pixel_t;

  typedef struct {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic               degenerate;
  } corrected_t;

  logic clk;
  logic rst_n;
  logic in_tvalid, in_tready;
  logic [47:0] in_tdata;     // distorted_x, distorted_y
  logic out_tvalid, out_tready;
  logic [47:0] out_tdata;    // undistorted_x, undistorted_y
  logic [0:0] out_tuser;     // degenerate
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  iterative_lens_undistort_unit dut (.*);

  // lens settings as the block should currently hold them
  cfg_t lens;
  pixel_t     pixel_q[$];      // pixels waiting to be offered
  corrected_t corrected_q[$];  // predicted results, oldest first
  int  mismatches;
  int  sender_idle_pct;
  int  receiver_stall_pct;
  longint cycles;

  // ---------------------------------------------------------------- predictor

  function automatic longint sat_q(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // nearest, ties upward
  function automatic longint round_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return sat_q(round_shift(a * b, FRAC));
  endfunction

  // nearest, ties away from zero, divisor positive
  function automatic longint div_near(input longint n, input longint d);
    longint a;
    longint q;
    a = (n < 0) ? -n : n;
    q = (a + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic longint back_to_pixel(input longint q, input longint f, input longint c,
                                           inout bit clamped);
    longint p;
    p = round_shift(q * f, FRAC) + c;
    if (p > 64'sd8388607) begin
      clamped = 1'b1;
      return 64'sd8388607;
    end
    if (p < -64'sd8388608) begin
      clamped = 1'b1;
      return -64'sd8388608;
    end
    return p;
  endfunction

  function automatic corrected_t undistort_pixel(input pixel_t px, input cfg_t c);
    longint u, v, fx, fy, cx, cy, k1, k2, k3, p1, p2;
    longint x0, y0, x, y, xx, yy, xy, r2, t, d, xy2, xx2, yy2, dx, dy, ic;
    bit flag;
    corrected_t r;
    u  = longint'(px.x);
    v  = longint'(px.y);
    fx = (c.focal_x != 0) ? longint'(c.focal_x) : 1;
    fy = (c.focal_y != 0) ? longint'(c.focal_y) : 1;
    cx = longint'(c.cx);
    cy = longint'(c.cy);
    k1 = longint'(c.k1);
    k2 = longint'(c.k2);
    k3 = longint'(c.k3);
    p1 = longint'(c.p1);
    p2 = longint'(c.p2);
    flag = 1'b0;
    x0 = sat_q(div_near((u - cx) <<< FRAC, fx));
    y0 = sat_q(div_near((v - cy) <<< FRAC, fy));
    x = x0;
    y = y0;
    for (int it = 0; it < ITERATIONS; it++) begin
      xx  = qmul(x, x);
      yy  = qmul(y, y);
      xy  = qmul(x, y);
      r2  = sat_q(xx + yy);
      t   = sat_q(qmul(k3, r2) + k2);
      t   = sat_q(qmul(t, r2) + k1);
      t   = qmul(t, r2);
      d   = sat_q((64'sd1 <<< FRAC) + t);
      xy2 = sat_q(2 * xy);
      xx2 = sat_q(2 * xx);
      yy2 = sat_q(2 * yy);
      dx  = sat_q(qmul(p1, xy2) + qmul(p2, sat_q(r2 + xx2)));
      dy  = sat_q(qmul(p1, sat_q(r2 + yy2)) + qmul(p2, xy2));
      // a non-positive denominator leaves the estimate where it was
      if (d <= 0) begin
        flag = 1'b1;
      end else begin
        ic = sat_q(div_near(64'sd1 <<< (2 * FRAC), d));
        x  = qmul(sat_q(x0 - dx), ic);
        y  = qmul(sat_q(y0 - dy), ic);
      end
    end
    r.x = 24'(back_to_pixel(x, fx, cx, flag));
    r.y = 24'(back_to_pixel(y, fy, cy, flag));
    r.degenerate = flag;
    return r;
  endfunction

  // ---------------------------------------------------------------- clock and limit

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("iterative_lens_undistort_unit verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driver

  // one nonblocking assignment per signal per edge; prediction taken at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        corrected_q.push_back(undistort_pixel(pixel_t'(in_tdata), lens));
      end
      if (!in_tvalid || in_tready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pixel_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    corrected_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
      if (out_tvalid && out_tready) begin
        if (corrected_q.size() == 0) begin
          report_mismatch("unexpected transaction, x", signed'(out_tdata[23:0]), 0);
        end else begin
          want = corrected_q.pop_front();
          if (out_tdata[23:0] !== want.x)
            report_mismatch("undistorted_x", signed'(out_tdata[23:0]), want.x);
          if (out_tdata[47:24] !== want.y)
            report_mismatch("undistorted_y", signed'(out_tdata[47:24]), want.y);
          if (out_tuser[0] !== want.degenerate)
            report_mismatch("degenerate", out_tuser[0], want.degenerate);
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequencing

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FOCAL_X:   lens.focal_x = val[23:0];
      REG_FOCAL_Y:   lens.focal_y = val[23:0];
      REG_PRINCIPAL: {lens.cx, lens.cy} = val[47:0];
      REG_RADIAL_K1: lens.k1 = val[31:0];
      REG_RADIAL_K2: lens.k2 = val[31:0];
      REG_RADIAL_K3: lens.k3 = val[31:0];
      REG_TAN_P1:    lens.p1 = val[31:0];
      REG_TAN_P2:    lens.p2 = val[31:0];
      default: ;
    endcase
  endtask

  task automatic load_lens(input cfg_t c);
    write_reg(REG_FOCAL_X, 48'(c.focal_x));
    write_reg(REG_FOCAL_Y, 48'(c.focal_y));
    write_reg(REG_PRINCIPAL, {c.cx, c.cy});
    write_reg(REG_RADIAL_K1, 48'(c.k1));
    write_reg(REG_RADIAL_K2, 48'(c.k2));
    write_reg(REG_RADIAL_K3, 48'(c.k3));
    write_reg(REG_TAN_P1, 48'(c.p1));
    write_reg(REG_TAN_P2, 48'(c.p2));
  endtask

  // wait for every pixel to go in and every result to come back, then let the pipe settle
  task automatic drain;
    @(posedge clk);
    while (pixel_q.size() != 0 || in_tvalid || corrected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic offer(input longint x, input longint y);
    pixel_t p;
    p.x = 24'(x);
    p.y = 24'(y);
    pixel_q.push_back(p);
  endtask

  // mostly a plausible lens, now and then anything at all
  function automatic cfg_t random_lens;
    cfg_t c;
    c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(3) != 0) begin
      c.focal_x = 24'($urandom_range(200 * 256, 2000 * 256));
      c.focal_y = 24'($urandom_range(200 * 256, 2000 * 256));
      c.cx = 24'($urandom_range(100 * 256, 1000 * 256));
      c.cy = 24'($urandom_range(100 * 256, 800 * 256));
      c.k1 = q24_t'($signed($urandom) >>> 7);
      c.k2 = q24_t'($signed($urandom) >>> 8);
      c.k3 = q24_t'($signed($urandom) >>> 9);
      c.p1 = q24_t'($signed($urandom) >>> 12);
      c.p2 = q24_t'($signed($urandom) >>> 12);
    end
    return c;
  endfunction

  task automatic random_pixels(input int n);
    repeat (n) begin
      if ($urandom_range(9) < 7)
        offer($urandom_range(2048 * 256), $urandom_range(2048 * 256));
      else
        offer($signed(24'($urandom)), $signed(24'($urandom)));
    end
  endtask

  initial begin
    cfg_t c;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_FOCAL_X;
    cfg_data = '0;
    cycles = 0;
    mismatches = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    lens = '{focal_x: 24'd128000, focal_y: 24'd128000, cx: 24'd81920, cy: 24'd61440,
             default: '0};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset lens: centre, corners of the field, origin
    offer(320 * 256, 240 * 256);
    offer(-8388608, -8388608);
    offer(8388607, 8388607);
    offer(-8388608, 8388607);
    offer(8388607, -8388608);
    offer(0, 0);
    drain();

    // k1 = -1 with a point one focal length off centre: denominator hits zero
    write_reg(REG_RADIAL_K1, 48'(-32'sd16777216));
    offer((320 + 500) * 256, 240 * 256);
    offer(320 * 256, (240 - 500) * 256);
    offer(320 * 256 + 5, 240 * 256);
    drain();
    // denominator one lsb above zero: reciprocal at full scale
    write_reg(REG_RADIAL_K1, 48'(-32'sd16777215));
    offer((320 + 500) * 256, 240 * 256);
    offer((320 - 500) * 256, 240 * 256);
    drain();
    // huge tangential terms push the output past the pixel range
    write_reg(REG_RADIAL_K1, 48'd0);
    write_reg(REG_TAN_P1, 48'(32'sh7fff_ffff));
    write_reg(REG_TAN_P2, 48'(32'sh8000_0000));
    offer(1000 * 256, 900 * 256);
    offer(-8388608, 8388607);
    drain();
    // zero focal lengths behave as one lsb; spare index must change nothing
    write_reg(REG_FOCAL_X, 48'd0);
    write_reg(REG_FOCAL_Y, 48'd0);
    write_reg(REG_SPARE, '1);
    offer(320 * 256 + 1, 240 * 256 - 1);
    offer(8388607, -8388608);
    offer(0, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: c = '{focal_x: 24'd0, focal_y: 24'd0, cx: 24'd0, cy: 24'd0,
                 default: q24_t'(32'sh8000_0000)};
        2: c = '{focal_x: 24'hffffff, focal_y: 24'hffffff, cx: 24'hffffff, cy: 24'hffffff,
                 default: q24_t'(32'sh7fff_ffff)};
        3: c = '{focal_x: 24'd256, focal_y: 24'd256, cx: 24'd0, cy: 24'hffffff,
                 k1: q24_t'(-32'sd4000000), default: '0};
        default: c = random_lens();
      endcase
      load_lens(c);
      case (ph % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 88; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 88; end
        default: begin sender_idle_pct = 29; receiver_stall_pct = 29; end
      endcase
      random_pixels(100);
      // sender holds off here until the pipeline has emptied
      if (ph == 3) drain();
      random_pixels(100);
      drain();
    end

    if (mismatches == 0) begin
      $display("iterative_lens_undistort_unit verification clean");
    end else begin
      $display("iterative_lens_undistort_unit verification failed");
    end
    $finish;
  end

endmodule
